// File: rtl/msb_pkg.sv
// Shared constants and types for the merge sort buffer.
// Used by the storage bank and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package msb_pkg;

  // Capacity of one list and the widths that follow from it.
  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Write side of one storage bank.
  typedef struct packed {
    logic  we;
    addr_t addr;
    word_t data;
  } bank_wr_t;

endpackage

`default_nettype wire

// File: rtl/msb_bank.sv
// Storage bank: one write port and two registered read ports.
// Depends on msb_pkg for depth and word width.
`timescale 1ns / 1ps
`default_nettype none

module msb_bank
  import msb_pkg::*;
(
  input  wire logic     clk,
  input  wire bank_wr_t wr,
  input  wire addr_t    raddr_a,
  input  wire addr_t    raddr_b,
  output word_t         rdata_a_r,
  output word_t         rdata_b_r
);

  word_t mem [MAX_ITEMS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Two read ports with registered data. A read of the word written in the
  // same cycle returns the new word, so a pass can start reading the bank
  // that the previous pass has just finished writing.
  always_ff @(posedge clk) begin
    rdata_a_r <= (wr.we && (wr.addr == raddr_a)) ? wr.data : mem[raddr_a];
    rdata_b_r <= (wr.we && (wr.addr == raddr_b)) ? wr.data : mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: rtl/merge_sort_buffer_unit.sv
// Merge sort buffer top level: load, bottom-up merge passes, emit.
// Depends on msb_pkg and two msb_bank instances used in ping-pong fashion.
// Loading takes one beat per cycle while start is high. After the beat marked last,
// a setup step and ceil(log2 N) merge passes sort N items (one merge write and one
// bank read pair per cycle); then N results follow, one per cycle.
// Reset (synchronous, active low) clears the sequencer, count and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module merge_sort_buffer_unit
  import msb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_value,
  input  wire logic        in_last,
  output logic             out_valid,
  output logic [31:0]      out_sorted_value,
  output logic             out_last_out,
  output logic             out_overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  logic   ovf_r, ovf_nxt;
  logic   sel_r, sel_nxt;      // 0: bank A is source, 1: bank B is source
  cnt_t   width_r, width_nxt;
  cnt_t   lo_r, lo_nxt;
  cnt_t   mid_r, mid_nxt;
  cnt_t   hi_r, hi_nxt;
  cnt_t   a_r, a_nxt;          // left run pointer, also the emit index
  cnt_t   b_r, b_nxt;
  cnt_t   w_r, w_nxt;

  bank_wr_t wr_a, wr_b;
  word_t    qa_a, qb_a, qa_b, qb_b;
  word_t    qa, qb, win;
  logic     a_done, b_done, take_a;
  logic [CNT_W:0] lo_next_wide, nw_wide, nw2_wide;
  cnt_t     nw, mid_new, hi_new, mid_first, hi_first;

  // Two banks; source and destination swap after every pass.
  msb_bank u_bank_a (
    .clk       (clk),
    .wr        (wr_a),
    .raddr_a   (a_nxt[ADDR_W-1:0]),
    .raddr_b   (b_nxt[ADDR_W-1:0]),
    .rdata_a_r (qa_a),
    .rdata_b_r (qb_a)
  );

  msb_bank u_bank_b (
    .clk       (clk),
    .wr        (wr_b),
    .raddr_a   (a_nxt[ADDR_W-1:0]),
    .raddr_b   (b_nxt[ADDR_W-1:0]),
    .rdata_a_r (qa_b),
    .rdata_b_r (qb_b)
  );

  // Head words of both runs come from the source bank.
  assign qa = sel_r ? qa_b : qa_a;
  assign qb = sel_r ? qb_b : qb_a;

  // Shared compare: left head wins unless spent, or not below an unspent right head.
  assign a_done = (a_r == mid_r);
  assign b_done = (b_r == hi_r);
  assign take_a = !a_done && (b_done || ($signed(qa) < $signed(qb)));
  assign win    = take_a ? qa : qb;

  // Bounds of the next run pair within this pass and of the first pair of the next pass.
  assign lo_next_wide = {1'b0, lo_r} + {width_r, 1'b0};
  assign nw_wide      = {width_r, 1'b0};
  assign nw           = nw_wide[CNT_W-1:0];
  assign nw2_wide     = {nw, 1'b0};

  always_comb begin
    logic [CNT_W:0] m_w, h_w;
    m_w = lo_next_wide + {1'b0, width_r};
    h_w = lo_next_wide + {width_r, 1'b0};
    mid_new   = (m_w > {1'b0, count_r}) ? count_r : m_w[CNT_W-1:0];
    hi_new    = (h_w > {1'b0, count_r}) ? count_r : h_w[CNT_W-1:0];
    mid_first = (nw_wide > {1'b0, count_r}) ? count_r : nw;
    hi_first  = (nw2_wide > {1'b0, count_r}) ? count_r : nw2_wide[CNT_W-1:0];
  end

  // Bank writes: loading fills bank A, merging writes the destination bank.
  always_comb begin
    wr_a = '{we: 1'b0, addr: w_r[ADDR_W-1:0], data: win};
    wr_b = '{we: 1'b0, addr: w_r[ADDR_W-1:0], data: win};
    if (state_r == ST_IDLE) begin
      wr_a.we   = start && (count_r < cnt_t'(MAX_ITEMS));
      wr_a.addr = count_r[ADDR_W-1:0];
      wr_a.data = in_value;
    end else if (state_r == ST_MERGE) begin
      wr_a.we = sel_r;
      wr_b.we = !sel_r;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    sel_nxt   = sel_r;
    width_nxt = width_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (count_r < cnt_t'(MAX_ITEMS)) begin
            count_nxt = count_r + cnt_t'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // First pass pairs runs of one element; a single item needs no sort.
        sel_nxt   = 1'b0;
        a_nxt     = '0;
        if (count_r == cnt_t'(1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MERGE;
          width_nxt = cnt_t'(1);
          lo_nxt    = '0;
          mid_nxt   = cnt_t'(1);
          hi_nxt    = cnt_t'(2);
          b_nxt     = cnt_t'(1);
          w_nxt     = '0;
        end
      end
      ST_MERGE: begin
        // One destination word per cycle.
        w_nxt = w_r + cnt_t'(1);
        if (take_a) begin
          a_nxt = a_r + cnt_t'(1);
        end else begin
          b_nxt = b_r + cnt_t'(1);
        end
        if (w_nxt == hi_r) begin
          if (lo_next_wide < {1'b0, count_r}) begin
            // Next run pair in the same pass.
            lo_nxt  = lo_next_wide[CNT_W-1:0];
            mid_nxt = mid_new;
            hi_nxt  = hi_new;
            a_nxt   = lo_next_wide[CNT_W-1:0];
            b_nxt   = mid_new;
          end else begin
            // Pass done: destination becomes source.
            sel_nxt   = !sel_r;
            width_nxt = nw;
            w_nxt     = '0;
            a_nxt     = '0;
            if (nw_wide >= {1'b0, count_r}) begin
              state_nxt = ST_EMIT;
            end else begin
              lo_nxt  = '0;
              mid_nxt = mid_first;
              hi_nxt  = hi_first;
              b_nxt   = mid_first;
            end
          end
        end
      end
      ST_EMIT: begin
        // One result per cycle in address order.
        a_nxt = a_r + cnt_t'(1);
        if (a_nxt == count_r) begin
          state_nxt = ST_IDLE;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      sel_r   <= 1'b0;
      width_r <= '0;
      lo_r    <= '0;
      mid_r   <= '0;
      hi_r    <= '0;
      a_r     <= '0;
      b_r     <= '0;
      w_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      sel_r   <= sel_nxt;
      width_r <= width_nxt;
      lo_r    <= lo_nxt;
      mid_r   <= mid_nxt;
      hi_r    <= hi_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      w_r     <= w_nxt;
    end
  end

  // Result beat comes straight from the registered read of the source bank.
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_EMIT);
  assign out_sorted_value = qa;
  assign out_last_out     = (state_r == ST_EMIT) && (a_r + cnt_t'(1) == count_r);
  assign out_overflow     = ovf_r;

endmodule

`default_nettype wire
